// ----- sv/pn3d_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pn3d_pkg
// Shared types, register map and the fixed permutation table of the noise unit.
// ============================================================================
package pn3d_pkg;

    // Width of the seed register and of a lattice cell index.
    localparam int SEED_W = 8;
    localparam int CELL_W = 8;
    // Hash bits that select a gradient.
    localparam int HASH_W = 4;

    // Register index of the seed within the configuration space.
    localparam logic REG_SEED = 1'b0;

    // Pipeline control shared by all stages.
    typedef struct packed {
        logic              adv;
        logic [SEED_W-1:0] seed;
    } t_pipe_ctl;

    typedef logic [CELL_W-1:0] t_cell;

    localparam logic [7:0] PERM_TAB [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // Seeded table read: the seed is added to the index modulo 256.
    function automatic t_cell perm_pick(input t_cell idx, input logic [SEED_W-1:0] seed);
        t_cell sum;
        sum = idx + seed;
        return PERM_TAB[sum];
    endfunction

endpackage

// ----- sv/perlin_noise_3d_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// perlin_noise_3d_unit
// Seeded improved gradient noise for one 3D fixed-point point per item.
// ============================================================================
// The unit takes one point per clock cycle unless the output stalls, and
// presents its noise value at the end of an 11-stage pipeline, whose first
// stage is loaded at the edge that accepts the item:
// three stages of chained permutation lookups (the fade runs alongside), one
// stage of gradient dot products, two stages for each of the three blend levels
// (multiply, then add), and a final shift and saturate stage. When the output
// item is not taken, the whole pipeline holds. The seed register sits at byte
// address 0 of the configuration port and should only be written while idle.
module perlin_noise_3d_unit #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int OUT_FRAC_BITS   = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input item channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    // Result item channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_noise_value,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int F     = COORD_FRAC_BITS;
    localparam int VW    = F + 3;
    localparam int NSTG  = 11;
    localparam int SHL   = (OUT_FRAC_BITS >= F) ? (OUT_FRAC_BITS - F) : 0;
    localparam int SHR   = (OUT_FRAC_BITS >= F) ? 0 : (F - OUT_FRAC_BITS);

    logic [pn3d_pkg::SEED_W-1:0] r_seed;
    logic [NSTG:1]               r_vld;
    pn3d_pkg::t_pipe_ctl         w_ctl;
    logic                        w_adv;

    // Configuration port: single seed register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == pn3d_pkg::REG_SEED) ? 32'(r_seed) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == pn3d_pkg::REG_SEED) begin
            r_seed <= pwdata[pn3d_pkg::SEED_W-1:0];
        end
    end

    // Pipeline advance: everything moves when the output stage is free or taken.
    assign w_adv   = !r_vld[NSTG] || i_ready;
    assign o_ready = w_adv;
    assign w_ctl   = '{adv: w_adv, seed: r_seed};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-1:1], i_valid};
        end
    end

    // Corner hashes (stages one to three).
    logic [pn3d_pkg::HASH_W-1:0] w_hash [8];

    pn3d_hash u_hash (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_cx   (i_pos_x[F+7:F]),
        .i_cy   (i_pos_y[F+7:F]),
        .i_cz   (i_pos_z[F+7:F]),
        .o_hash (w_hash)
    );

    // Fade weights (stages one to three).
    logic [F:0] w_fu, w_fv, w_fw;

    pn3d_fade #(.FRAC_BITS(F)) u_fade_x (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_t (i_pos_x[F-1:0]), .o_fade (w_fu)
    );
    pn3d_fade #(.FRAC_BITS(F)) u_fade_y (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_t (i_pos_y[F-1:0]), .o_fade (w_fv)
    );
    pn3d_fade #(.FRAC_BITS(F)) u_fade_z (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_t (i_pos_z[F-1:0]), .o_fade (w_fw)
    );

    // Fractions travel alongside the hash lookups.
    logic [F-1:0] r_fx [1:3];
    logic [F-1:0] r_fy [1:3];
    logic [F-1:0] r_fz [1:3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fx[1] <= i_pos_x[F-1:0];
            r_fy[1] <= i_pos_y[F-1:0];
            r_fz[1] <= i_pos_z[F-1:0];
            for (int s = 2; s <= 3; s++) begin
                r_fx[s] <= r_fx[s-1];
                r_fy[s] <= r_fy[s-1];
                r_fz[s] <= r_fz[s-1];
            end
        end
    end

    // Gradient dot product for one corner.
    function automatic logic signed [VW-1:0] slope(
        input logic [pn3d_pkg::HASH_W-1:0] k,
        input logic signed [VW-1:0]        x,
        input logic signed [VW-1:0]        y,
        input logic signed [VW-1:0]        z
    );
        logic signed [VW-1:0] u;
        logic signed [VW-1:0] v;
        u = (k < 4'd8) ? x : y;
        v = (k < 4'd4) ? y : ((k == 4'd12 || k == 4'd14) ? x : z);
        return (k[0] ? -u : u) + (k[1] ? -v : v);
    endfunction

    // Relative coordinates: the near corner is the fraction, the far one is
    // the fraction minus one.
    logic signed [VW-1:0] w_rx [2];
    logic signed [VW-1:0] w_ry [2];
    logic signed [VW-1:0] w_rz [2];

    assign w_rx[0] = {3'b000, r_fx[3]};
    assign w_rx[1] = {3'b111, r_fx[3]};
    assign w_ry[0] = {3'b000, r_fy[3]};
    assign w_ry[1] = {3'b111, r_fy[3]};
    assign w_rz[0] = {3'b000, r_fz[3]};
    assign w_rz[1] = {3'b111, r_fz[3]};

    // Stage four: eight corner gradients and the fade weights lined up.
    logic signed [VW-1:0] r_g [8];
    logic [F:0]           r_u4;
    logic [F:0]           r_vd [4:6];
    logic [F:0]           r_wd [4:8];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < 8; j++) begin
                r_g[j] <= slope(w_hash[j], w_rx[j[0]], w_ry[j[1]], w_rz[j[2]]);
            end
            r_u4    <= w_fu;
            r_vd[4] <= w_fv;
            r_wd[4] <= w_fw;
            for (int s = 5; s <= 6; s++) begin
                r_vd[s] <= r_vd[s-1];
            end
            for (int s = 5; s <= 8; s++) begin
                r_wd[s] <= r_wd[s-1];
            end
        end
    end

    // Stages five and six: blend along x.
    logic signed [VW-1:0] w_x [4];

    for (genvar i = 0; i < 4; i++) begin : g_lerp_x
        pn3d_lerp #(.FRAC_BITS(F), .VW(VW)) u_lerp (
            .i_clk (i_clk), .i_ctl (w_ctl),
            .i_a (r_g[2*i]), .i_b (r_g[2*i+1]), .i_w (r_u4), .o_y (w_x[i])
        );
    end

    // Stages seven and eight: blend along y.
    logic signed [VW-1:0] w_lo, w_hi;

    pn3d_lerp #(.FRAC_BITS(F), .VW(VW)) u_lerp_lo (
        .i_clk (i_clk), .i_ctl (w_ctl),
        .i_a (w_x[0]), .i_b (w_x[1]), .i_w (r_vd[6]), .o_y (w_lo)
    );
    pn3d_lerp #(.FRAC_BITS(F), .VW(VW)) u_lerp_hi (
        .i_clk (i_clk), .i_ctl (w_ctl),
        .i_a (w_x[2]), .i_b (w_x[3]), .i_w (r_vd[6]), .o_y (w_hi)
    );

    // Stages nine and ten: blend along z.
    logic signed [VW-1:0] w_r;

    pn3d_lerp #(.FRAC_BITS(F), .VW(VW)) u_lerp_z (
        .i_clk (i_clk), .i_ctl (w_ctl),
        .i_a (w_lo), .i_b (w_hi), .i_w (r_wd[8]), .o_y (w_r)
    );

    // Stage eleven: rescale to the output format and saturate.
    logic signed [63:0] w_ext, w_scaled;
    logic signed [15:0] r_out;

    assign w_ext    = 64'(w_r);
    assign w_scaled = (OUT_FRAC_BITS >= F) ? (w_ext <<< SHL) : (w_ext >>> SHR);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_scaled > 64'sd32767) begin
                r_out <= 16'sh7fff;
            end else if (w_scaled < -64'sd32768) begin
                r_out <= 16'sh8000;
            end else begin
                r_out <= w_scaled[15:0];
            end
        end
    end

    assign o_valid       = r_vld[NSTG];
    assign o_noise_value = r_out;

endmodule

// ----- sv/pn3d_hash.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pn3d_hash
// Three-stage corner hash: one chained permutation lookup per stage.
// ============================================================================
module pn3d_hash (
    input  logic                             i_clk,
    input  pn3d_pkg::t_pipe_ctl              i_ctl,
    input  pn3d_pkg::t_cell                  i_cx,
    input  pn3d_pkg::t_cell                  i_cy,
    input  pn3d_pkg::t_cell                  i_cz,
    output logic [pn3d_pkg::HASH_W-1:0]      o_hash [8]
);

    pn3d_pkg::t_cell r_a, r_b, r_cz1, r_cz2;
    pn3d_pkg::t_cell r_aa, r_ab, r_ba, r_bb;
    logic [pn3d_pkg::HASH_W-1:0] r_h [8];

    // Stage one: hash of the x cell, offset by the y cell.
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_a   <= pn3d_pkg::perm_pick(i_cx, i_ctl.seed) + i_cy;
            r_b   <= pn3d_pkg::perm_pick(i_cx + 8'd1, i_ctl.seed) + i_cy;
            r_cz1 <= i_cz;
        end
    end

    // Stage two: the four xy corners, offset by the z cell.
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_aa  <= pn3d_pkg::perm_pick(r_a, i_ctl.seed) + r_cz1;
            r_ab  <= pn3d_pkg::perm_pick(r_a + 8'd1, i_ctl.seed) + r_cz1;
            r_ba  <= pn3d_pkg::perm_pick(r_b, i_ctl.seed) + r_cz1;
            r_bb  <= pn3d_pkg::perm_pick(r_b + 8'd1, i_ctl.seed) + r_cz1;
            r_cz2 <= r_cz1;
        end
    end

    // Stage three: the eight corner hashes, corner index ordered {dz, dy, dx}.
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_h[0] <= pn3d_pkg::HASH_W'(pn3d_pkg::perm_pick(r_aa, i_ctl.seed));
            r_h[1] <= pn3d_pkg::HASH_W'(pn3d_pkg::perm_pick(r_ba, i_ctl.seed));
            r_h[2] <= pn3d_pkg::HASH_W'(pn3d_pkg::perm_pick(r_ab, i_ctl.seed));
            r_h[3] <= pn3d_pkg::HASH_W'(pn3d_pkg::perm_pick(r_bb, i_ctl.seed));
            r_h[4] <= pn3d_pkg::HASH_W'(pn3d_pkg::perm_pick(r_aa + 8'd1, i_ctl.seed));
            r_h[5] <= pn3d_pkg::HASH_W'(pn3d_pkg::perm_pick(r_ba + 8'd1, i_ctl.seed));
            r_h[6] <= pn3d_pkg::HASH_W'(pn3d_pkg::perm_pick(r_ab + 8'd1, i_ctl.seed));
            r_h[7] <= pn3d_pkg::HASH_W'(pn3d_pkg::perm_pick(r_bb + 8'd1, i_ctl.seed));
        end
    end

    // The z cell is only needed through stage two; keep it for symmetry of timing.
    assign o_hash = r_h;

    logic w_unused;
    assign w_unused = ^r_cz2;

endmodule

// ----- sv/pn3d_fade.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pn3d_fade
// Three-stage quintic fade 6t^5 - 15t^4 + 10t^3 in fixed point.
// ============================================================================
module pn3d_fade #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  pn3d_pkg::t_pipe_ctl    i_ctl,
    input  logic [FRAC_BITS-1:0]   i_t,
    output logic [FRAC_BITS:0]     o_fade
);

    localparam int PW = FRAC_BITS + 4;
    localparam int MW = 2 * FRAC_BITS + 4;

    logic [FRAC_BITS-1:0] r_t2, r_t1, r_t3;
    logic [PW-1:0]        r_p;
    logic [FRAC_BITS:0]   r_fade;

    logic [2*FRAC_BITS-1:0] w_sq, w_cube;
    logic [PW:0]            w_p;
    logic [MW-1:0]          w_prod;

    // Stage one: t squared.
    assign w_sq = (2*FRAC_BITS)'(i_t) * (2*FRAC_BITS)'(i_t);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_t2 <= w_sq[2*FRAC_BITS-1:FRAC_BITS];
            r_t1 <= i_t;
        end
    end

    // Stage two: t cubed and the polynomial 6t^2 - 15t + 10, which stays positive.
    assign w_cube = (2*FRAC_BITS)'(r_t2) * (2*FRAC_BITS)'(r_t1);
    assign w_p    = (PW+1)'(r_t2) * (PW+1)'(6) + ((PW+1)'(10) << FRAC_BITS)
                  - (PW+1)'(r_t1) * (PW+1)'(15);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_t3 <= w_cube[2*FRAC_BITS-1:FRAC_BITS];
            r_p  <= w_p[PW-1:0];
        end
    end

    // Stage three: fade value in [0, 1].
    assign w_prod = MW'(r_t3) * MW'(r_p);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_fade <= w_prod[2*FRAC_BITS:FRAC_BITS];
        end
    end

    assign o_fade = r_fade;

    logic w_unused;
    assign w_unused = ^i_ctl.seed;

endmodule

// ----- sv/pn3d_lerp.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pn3d_lerp
// Two-stage linear blend a + floor(w * (b - a) / 2^F).
// ============================================================================
module pn3d_lerp #(
    parameter int FRAC_BITS = 16,
    parameter int VW        = 19
) (
    input  logic                     i_clk,
    input  pn3d_pkg::t_pipe_ctl      i_ctl,
    input  logic signed [VW-1:0]     i_a,
    input  logic signed [VW-1:0]     i_b,
    input  logic [FRAC_BITS:0]       i_w,
    output logic signed [VW-1:0]     o_y
);

    localparam int PW = VW + FRAC_BITS + 3;

    logic signed [VW:0]    w_d;
    logic signed [PW-1:0]  w_d_ext, w_w_ext, w_prod, w_sh, w_a_ext;
    logic signed [VW-1:0]  r_a, r_y;
    logic signed [PW-1:0]  r_prod;

    // Stage one: difference times weight.
    assign w_d     = VW'(i_b) - VW'(i_a) + (VW+1)'(0);
    assign w_d_ext = PW'(w_d);
    assign w_w_ext = PW'({1'b0, i_w});
    assign w_prod  = w_d_ext * w_w_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_a    <= i_a;
            r_prod <= w_prod;
        end
    end

    // Stage two: scale down with floor and add the base.
    assign w_sh    = r_prod >>> FRAC_BITS;
    assign w_a_ext = PW'(r_a);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_y <= VW'(w_a_ext + w_sh);
        end
    end

    assign o_y = r_y;

    logic w_unused;
    assign w_unused = ^i_ctl.seed;

endmodule
